// ===== hdl/rmcw_pkg.sv =====
// Package for the antenna rotator motor controller with command watchdog.
// Holds the operation, command, motor and reply codes, field widths and reset values.
// No dependencies; used by the top level and its checker.

package rmcw_pkg;

    // Default width of the report and heartbeat timers.
    localparam int TIMER_BITS_DEFAULT = 16;

    // Field widths of one input beat.
    localparam int OP_W      = 2;
    localparam int CMD_W     = 4;
    localparam int SAMPLE_W  = 12;
    localparam int IN_TDATA_W = 32;

    // Field widths of one result beat.
    localparam int KIND_W     = 2;
    localparam int REPLY_AZ_W = 12;
    localparam int REPLY_EL_W = 11;
    localparam int OUT_TDATA_W = 32;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MS_W        = 16;

    // Saturating count of milliseconds since the last command.
    localparam int SINCE_W = 17;

    // Elevation clamp in tenths of a degree.
    localparam logic [REPLY_EL_W-1:0] EL_MAX = 11'd1800;

    // Configuration reset values.
    localparam logic [MS_W-1:0] TIMEOUT_RESET   = 16'd3000;
    localparam logic [MS_W-1:0] REPORT_RESET    = 16'd500;
    localparam logic [MS_W-1:0] HEARTBEAT_RESET = 16'd1000;

    // Operation codes carried in the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_COMMAND = 2'd1,
        OP_SAMPLE  = 2'd2
    } op_t;

    // Command codes; the rest are unknown and only clear the watchdog count.
    typedef enum logic [CMD_W-1:0] {
        CMD_ECHO      = 4'd0,
        CMD_CW        = 4'd1,
        CMD_CCW       = 4'd2,
        CMD_UP        = 4'd3,
        CMD_DOWN      = 4'd4,
        CMD_STOP_AZ   = 4'd5,
        CMD_STOP_EL   = 4'd6,
        CMD_STOP_ALL  = 4'd7,
        CMD_GET_POS   = 4'd8
    } cmd_t;

    // Motor state of one axis: forward is cw or up, reverse is ccw or down.
    typedef enum logic [1:0] {
        MOTOR_STOP = 2'd0,
        MOTOR_FWD  = 2'd1,
        MOTOR_REV  = 2'd2
    } motor_t;

    // Reply kinds carried in the result tuser.
    typedef enum logic [KIND_W-1:0] {
        REPLY_NONE   = 2'd0,
        REPLY_PONG   = 2'd1,
        REPLY_REPORT = 2'd2
    } reply_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT     = 2'd0,
        CFG_REPORT      = 2'd1,
        CFG_HEARTBEAT   = 2'd2,
        CFG_ACTIVE_HIGH = 2'd3
    } cfg_index_t;

    // One result beat.
    typedef struct packed {
        reply_t                  reply_kind;
        logic [REPLY_EL_W-1:0]   reply_elevation;
        logic [REPLY_AZ_W-1:0]   reply_azimuth;
        logic                    timeout_stop;
        logic                    heartbeat_led;
        logic                    el_down_relay;
        logic                    el_up_relay;
        logic                    az_ccw_relay;
        logic                    az_cw_relay;
    } result_t;

endpackage

// ===== hdl/rotator_motor_command_watchdog.sv =====
// Antenna rotator motor controller with command watchdog: top level.
// Input register, single-pass state update, and a two-entry result buffer.
// Depends on rmcw_pkg.
//
// Items pass the input register, then the output or skid register.
// Throughput: one item per cycle until the skid register holds a stalled beat.
// Reset (rst_n low, asynchronous): motors stopped, timers, LED and positions
// cleared, configuration back to its defaults, both channels empty.

module rotator_motor_command_watchdog #(
    parameter int TIMER_BITS = rmcw_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // command_code [3:0], azimuth_sample [15:4], elevation_sample [27:16], zero above
    input  logic [rmcw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation [1:0]
    input  logic [rmcw_pkg::OP_W-1:0]           s_axis_tuser,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // az_cw_relay [0], az_ccw_relay [1], el_up_relay [2], el_down_relay [3],
    // heartbeat_led [4], timeout_stop [5], reply_azimuth [17:6],
    // reply_elevation [28:18], zero above
    output logic [rmcw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // reply_kind [1:0]
    output logic [rmcw_pkg::KIND_W-1:0]         m_axis_tuser,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rmcw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rmcw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CMP_W = (TIMER_BITS > rmcw_pkg::MS_W) ? TIMER_BITS : rmcw_pkg::MS_W;
    localparam int OUT_PAD_W = rmcw_pkg::OUT_TDATA_W - 29;

    // Configuration registers.
    logic [rmcw_pkg::MS_W-1:0] timeout_reg;
    logic [rmcw_pkg::MS_W-1:0] report_int_reg;
    logic [rmcw_pkg::MS_W-1:0] heartbeat_int_reg;
    logic                      active_high_reg;

    // Block state.
    rmcw_pkg::motor_t                az_motor_reg, az_motor_next;
    rmcw_pkg::motor_t                el_motor_reg, el_motor_next;
    logic [rmcw_pkg::SINCE_W-1:0]    since_reg, since_next;
    logic [TIMER_BITS-1:0]           report_timer_reg, report_timer_next;
    logic [TIMER_BITS-1:0]           heartbeat_timer_reg, heartbeat_timer_next;
    logic                            led_reg, led_next;
    logic [rmcw_pkg::SAMPLE_W-1:0]   az_pos_reg, az_pos_next;
    logic [rmcw_pkg::REPLY_EL_W-1:0] el_pos_reg, el_pos_next;

    // Input register.
    logic                            in_valid_reg, in_valid_next;
    rmcw_pkg::op_t                   in_op_reg;
    logic [rmcw_pkg::CMD_W-1:0]      in_cmd_reg;
    logic [rmcw_pkg::SAMPLE_W-1:0]   in_az_reg;
    logic [rmcw_pkg::SAMPLE_W-1:0]   in_el_reg;

    // Result buffer: output register and skid register.
    logic                            out_valid_reg, out_valid_next;
    logic                            skid_valid_reg, skid_valid_next;
    rmcw_pkg::result_t               out_data_reg, out_data_next;
    rmcw_pkg::result_t               skid_data_reg, skid_data_next;

    logic                            in_accept;
    logic                            advance;
    logic                            out_take;
    rmcw_pkg::result_t               result;

    logic [TIMER_BITS-1:0]           report_inc;
    logic [TIMER_BITS-1:0]           heartbeat_inc;
    rmcw_pkg::reply_t                reply;
    logic                            tstop;

    // Handshakes.
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign advance       = in_valid_reg && !skid_valid_reg;
    assign out_take      = out_valid_reg && m_axis_tready;
    assign s_axis_tready = !in_valid_reg || !skid_valid_reg;
    assign cfg_ready     = 1'b1;

    // Saturating timer increments.
    assign report_inc    = (&report_timer_reg) ? report_timer_reg
                                               : report_timer_reg + 1'b1;
    assign heartbeat_inc = (&heartbeat_timer_reg) ? heartbeat_timer_reg
                                                  : heartbeat_timer_reg + 1'b1;

    // Single-pass update of the state for the item in the input register.
    always_comb
    begin
        az_motor_next        = az_motor_reg;
        el_motor_next        = el_motor_reg;
        since_next           = since_reg;
        report_timer_next    = report_timer_reg;
        heartbeat_timer_next = heartbeat_timer_reg;
        led_next             = led_reg;
        az_pos_next          = az_pos_reg;
        el_pos_next          = el_pos_reg;
        reply                = rmcw_pkg::REPLY_NONE;
        tstop                = 1'b0;

        case (in_op_reg)
            rmcw_pkg::OP_TICK:
            begin
                if (!(&since_reg))
                begin
                    since_next = since_reg + 1'b1;
                end
                report_timer_next = report_inc;
                if (CMP_W'(report_inc) >= CMP_W'(report_int_reg))
                begin
                    report_timer_next = '0;
                    reply             = rmcw_pkg::REPLY_REPORT;
                end
                heartbeat_timer_next = heartbeat_inc;
                if (CMP_W'(heartbeat_inc) >= CMP_W'(heartbeat_int_reg))
                begin
                    heartbeat_timer_next = '0;
                    led_next             = !led_reg;
                end
            end
            rmcw_pkg::OP_COMMAND:
            begin
                since_next = '0;
                case (in_cmd_reg)
                    rmcw_pkg::CMD_ECHO:     reply = rmcw_pkg::REPLY_PONG;
                    rmcw_pkg::CMD_CW:       az_motor_next = rmcw_pkg::MOTOR_FWD;
                    rmcw_pkg::CMD_CCW:      az_motor_next = rmcw_pkg::MOTOR_REV;
                    rmcw_pkg::CMD_UP:       el_motor_next = rmcw_pkg::MOTOR_FWD;
                    rmcw_pkg::CMD_DOWN:     el_motor_next = rmcw_pkg::MOTOR_REV;
                    rmcw_pkg::CMD_STOP_AZ:  az_motor_next = rmcw_pkg::MOTOR_STOP;
                    rmcw_pkg::CMD_STOP_EL:  el_motor_next = rmcw_pkg::MOTOR_STOP;
                    rmcw_pkg::CMD_STOP_ALL:
                    begin
                        az_motor_next = rmcw_pkg::MOTOR_STOP;
                        el_motor_next = rmcw_pkg::MOTOR_STOP;
                    end
                    rmcw_pkg::CMD_GET_POS:  reply = rmcw_pkg::REPLY_REPORT;
                    default:                reply = rmcw_pkg::REPLY_NONE;
                endcase
            end
            rmcw_pkg::OP_SAMPLE:
            begin
                az_pos_next = in_az_reg;
                if (in_el_reg > rmcw_pkg::SAMPLE_W'(rmcw_pkg::EL_MAX))
                begin
                    el_pos_next = rmcw_pkg::EL_MAX;
                end
                else
                begin
                    el_pos_next = in_el_reg[rmcw_pkg::REPLY_EL_W-1:0];
                end
            end
            default:
            begin
                reply = rmcw_pkg::REPLY_NONE;
            end
        endcase

        // Watchdog, checked on every item.
        if ((az_motor_next != rmcw_pkg::MOTOR_STOP || el_motor_next != rmcw_pkg::MOTOR_STOP)
            && since_next > rmcw_pkg::SINCE_W'(timeout_reg))
        begin
            az_motor_next = rmcw_pkg::MOTOR_STOP;
            el_motor_next = rmcw_pkg::MOTOR_STOP;
            tstop         = 1'b1;
        end
    end

    // Result fields; every relay pin is inverted when relays are active low.
    always_comb
    begin
        result.reply_kind    = reply;
        result.az_cw_relay   = (az_motor_next == rmcw_pkg::MOTOR_FWD) ^ !active_high_reg;
        result.az_ccw_relay  = (az_motor_next == rmcw_pkg::MOTOR_REV) ^ !active_high_reg;
        result.el_up_relay   = (el_motor_next == rmcw_pkg::MOTOR_FWD) ^ !active_high_reg;
        result.el_down_relay = (el_motor_next == rmcw_pkg::MOTOR_REV) ^ !active_high_reg;
        result.heartbeat_led = led_next;
        result.timeout_stop  = tstop;
        if (reply == rmcw_pkg::REPLY_REPORT)
        begin
            result.reply_azimuth   = az_pos_next;
            result.reply_elevation = el_pos_next;
        end
        else
        begin
            result.reply_azimuth   = '0;
            result.reply_elevation = '0;
        end
    end

    // Next values of the input register and the result buffer.
    always_comb
    begin
        in_valid_next   = in_valid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        if (out_take || !out_valid_reg)
        begin
            // Output register is free: refill from the skid beat first.
            if (skid_valid_reg)
            begin
                out_data_next = skid_data_reg;
            end
            else
            begin
                out_data_next = result;
            end
            out_valid_next  = skid_valid_reg || advance;
            skid_valid_next = 1'b0;
        end
        else if (advance)
        begin
            // Output beat stalls: park the new result in the skid register.
            skid_data_next  = result;
            skid_valid_next = 1'b1;
        end
    end

    // Control state, block state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg         <= rmcw_pkg::TIMEOUT_RESET;
            report_int_reg      <= rmcw_pkg::REPORT_RESET;
            heartbeat_int_reg   <= rmcw_pkg::HEARTBEAT_RESET;
            active_high_reg     <= 1'b1;
            az_motor_reg        <= rmcw_pkg::MOTOR_STOP;
            el_motor_reg        <= rmcw_pkg::MOTOR_STOP;
            since_reg           <= '0;
            report_timer_reg    <= '0;
            heartbeat_timer_reg <= '0;
            led_reg             <= 1'b0;
            az_pos_reg          <= '0;
            el_pos_reg          <= '0;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;

            if (advance)
            begin
                az_motor_reg        <= az_motor_next;
                el_motor_reg        <= el_motor_next;
                since_reg           <= since_next;
                report_timer_reg    <= report_timer_next;
                heartbeat_timer_reg <= heartbeat_timer_next;
                led_reg             <= led_next;
                az_pos_reg          <= az_pos_next;
                el_pos_reg          <= el_pos_next;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rmcw_pkg::CFG_TIMEOUT:     timeout_reg       <= cfg_data;
                    rmcw_pkg::CFG_REPORT:      report_int_reg    <= cfg_data;
                    rmcw_pkg::CFG_HEARTBEAT:   heartbeat_int_reg <= cfg_data;
                    rmcw_pkg::CFG_ACTIVE_HIGH: active_high_reg   <= cfg_data[0];
                    default:                   active_high_reg   <= active_high_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg  <= rmcw_pkg::op_t'(s_axis_tuser);
            in_cmd_reg <= s_axis_tdata[3:0];
            in_az_reg  <= s_axis_tdata[15:4];
            in_el_reg  <= s_axis_tdata[27:16];
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Result stream.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.reply_kind;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}},
                            out_data_reg.reply_elevation,
                            out_data_reg.reply_azimuth,
                            out_data_reg.timeout_stop,
                            out_data_reg.heartbeat_led,
                            out_data_reg.el_down_relay,
                            out_data_reg.el_up_relay,
                            out_data_reg.az_ccw_relay,
                            out_data_reg.az_cw_relay};

endmodule

// ===== hdl/rmcw_checker.sv =====
// Port-level checker for the rotator motor controller, bound to the top level.
// Watches the result stream only. Depends on rmcw_pkg.

module rmcw_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rmcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [rmcw_pkg::KIND_W-1:0]      m_axis_tuser
);

    // A beat that reports a watchdog stop shows all four relays at the same level.
    a_stop_relays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |->
        (m_axis_tdata[0] == m_axis_tdata[1] && m_axis_tdata[1] == m_axis_tdata[2]
         && m_axis_tdata[2] == m_axis_tdata[3]))
        else $error("watchdog stop with a relay energized");

    // Positions travel only with a position report.
    a_no_stray_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != rmcw_pkg::REPLY_REPORT) |->
        (m_axis_tdata[28:6] == '0))
        else $error("position fields set without a report");

    // Reported elevation stays within the clamp.
    a_elevation_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[28:18] <= rmcw_pkg::EL_MAX))
        else $error("reported elevation above the clamp");

    // A stalled result beat holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result beat changed");

endmodule

bind rotator_motor_command_watchdog rmcw_checker u_rmcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
